[rtl/core/lcs_pkg.sv]
package lcs_pkg;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_FRAC_BITS = 12;

  localparam int PIX_W    = 8;
  localparam int WEIGHT_W = 22;
  localparam int MOMENT_W = 30;
  localparam int POS_W    = 16;
  localparam int CFG_W    = 22;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_VELOCITY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_DECEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX       = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accumulate;
    logic div_start;
    logic pos_load;
    logic vel_start;
    logic wheel_calc;
    logic out_load;
  } lcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic pos_needed;
  } lcs_status_t;

  typedef struct packed {
    logic              update_valid;
    logic [POS_W-1:0]  steer_position;
    logic              left_reverse;
    logic [7:0]        left_duty;
    logic              right_reverse;
    logic [7:0]        right_duty;
  } lcs_result_t;

endpackage

[rtl/core/lcs_if.sv]
interface lcs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface lcs_result_if;
  logic        valid;
  logic        ready;
  logic        update_valid;
  logic [15:0] steer_position;
  logic        left_reverse;
  logic [7:0]  left_duty;
  logic        right_reverse;
  logic [7:0]  right_duty;
  modport source (output valid, update_valid, steer_position, left_reverse, left_duty,
                  right_reverse, right_duty, input ready);
  modport sink (input valid, update_valid, steer_position, left_reverse, left_duty,
                right_reverse, right_duty, output ready);
endinterface

[rtl/core/lcs_divider.sv]
module lcs_divider
  import lcs_pkg::*;
#(
  parameter int N = 64,
  parameter int D = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0] num;
  logic [D:0]   rem;
  logic [D-1:0] den;
  logic [CW-1:0] count;
  logic         busy;
  logic [D:0]   trial;

  // One quotient bit per cycle, restoring.
  assign trial = {rem[D-1:0], num[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(N);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[N-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem <= trial;
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/lcs_datapath.sv]
module lcs_datapath
  import lcs_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  lcs_cmd_t          cmd,
  output lcs_status_t       status,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              frame_start,
  input  logic [8:0]        cfg_line_width,
  input  logic [6:0]        cfg_line_count,
  input  logic [21:0]       cfg_min_weight,
  input  logic [14:0]       cfg_pos_gain,
  input  logic [15:0]       cfg_base_velocity,
  input  logic [14:0]       cfg_curve_decel,
  input  logic [7:0]        cfg_pwm_max,
  output lcs_result_t       result
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_ROWS + 1);
  localparam int ONE_SH = 16 + FRAC_BITS;
  localparam int DIV_N = 64;
  localparam int DIV_D = 40;

  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [WEIGHT_W-1:0] wsum;
  logic [MOMENT_W-1:0] msum;
  logic [POS_W-1:0]    held;
  logic                updated;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  always_comb begin
    if (cfg_line_width == 9'd0) w_eff = WID_W'(1);
    else if (32'(cfg_line_width) > MAX_WIDTH) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = WID_W'(cfg_line_width);
    if (cfg_line_count == 7'd0) h_eff = HGT_W'(1);
    else if (32'(cfg_line_count) > MAX_ROWS) h_eff = HGT_W'(MAX_ROWS);
    else h_eff = HGT_W'(cfg_line_count);
  end

  // Accumulation of the current pixel; a frame mark clears first.
  logic [COL_W-1:0]    col_in;
  logic [ROW_W-1:0]    row_in;
  logic [WEIGHT_W-1:0] wsum_in;
  logic [MOMENT_W-1:0] msum_in;
  logic [PIX_W-1:0]    weight;
  logic [WEIGHT_W:0]   wadd;
  logic [MOMENT_W:0]   madd;
  logic [WEIGHT_W-1:0] wsat;
  logic                line_end;
  logic                frm_end;

  assign col_in  = frame_start ? '0 : col;
  assign row_in  = frame_start ? '0 : row;
  assign wsum_in = frame_start ? '0 : wsum;
  assign msum_in = frame_start ? '0 : msum;
  assign weight  = 8'd255 - pixel;
  assign wadd = {1'b0, wsum_in} + (WEIGHT_W + 1)'(weight);
  assign madd = {1'b0, msum_in} + (MOMENT_W + 1)'(weight) * (MOMENT_W + 1)'(col_in);
  assign wsat = wadd[WEIGHT_W] ? '1 : wadd[WEIGHT_W-1:0];
  assign line_end = (32'(col_in) + 1) >= 32'(w_eff);
  assign frm_end  = line_end && ((32'(row_in) + 1) >= 32'(h_eff));

  // Division unit, shared by the position and the velocity quotients.
  logic             div_go;
  logic [DIV_N-1:0] div_num;
  logic [DIV_D-1:0] div_den;
  logic             div_done;
  logic [DIV_N-1:0] div_q;
  logic             pos_phase;
  logic             div_pos;

  lcs_divider #(.N(DIV_N), .D(DIV_D)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_num), .divisor(div_den),
    .done(div_done), .quotient(div_q)
  );

  assign status = '{frame_end: frm_end, div_done: div_done, pos_needed: pos_phase};

  logic        diff_neg;
  logic [38:0] diff_mag;
  logic [40:0] diff_s;
  logic [53:0] pmag;
  logic [39:0] pden;
  logic [15:0] absc;
  logic [39:0] vden;
  logic [DIV_N-1:0] vnum;
  logic [15:0] vm;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      wsum <= '0;
      msum <= '0;
      held <= '0;
      updated <= 1'b0;
      pos_phase <= 1'b0;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cmd.accumulate) begin
        if (frm_end) begin
          col <= '0;
          row <= '0;
          updated <= 1'b0;
          if (wsat > cfg_min_weight) begin
            pos_phase <= 1'b1;
          end else begin
            pos_phase <= 1'b0;
          end
        end else if (line_end) begin
          col <= '0;
          row <= row_in + 1'b1;
        end else begin
          col <= col_in + 1'b1;
          row <= row_in;
        end
        wsum <= wsat;
        msum <= madd[MOMENT_W] ? '1 : madd[MOMENT_W-1:0];
      end
      if (cmd.div_start) begin
        div_go <= 1'b1;
      end
      if (cmd.pos_load) begin
        pos_phase <= 1'b0;
        wsum <= '0;
        msum <= '0;
        if (div_pos) begin
          updated <= 1'b1;
          if (div_q >= 64'd32768) held <= diff_neg ? 16'h8000 : 16'h7FFF;
          else if (diff_neg) held <= 16'(-div_q[15:0]);
          else held <= div_q[15:0];
        end
      end
    end
  end

  // Operand capture for the division; pos_phase chooses position or velocity.
  assign div_pos = pos_phase;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      diff_s <= 41'($signed({11'd0, msum, 1'b0})) -
                41'($signed({1'b0, 32'(w_eff) * 32'(wsum)}));
    end
  end

  assign diff_neg = diff_s[40];
  assign diff_mag = diff_neg ? 39'(-diff_s) : diff_s[38:0];
  assign pmag = 54'(diff_mag) * 54'(cfg_pos_gain);
  assign pden = 40'(32'(w_eff) * 32'(wsum)) << 1;
  assign absc = held[15] ? 16'(-held) : held;
  assign vden = (40'd1 << (2 * FRAC_BITS)) + 40'(absc) * 40'(cfg_curve_decel);
  assign vnum = DIV_N'(cfg_base_velocity) << (2 * FRAC_BITS);

  // The divider takes the operands in the cycle after div_start, when diff_s is set.
  assign div_num = div_pos ? DIV_N'(pmag) : vnum;
  assign div_den = div_pos ? pden : vden;

  always_ff @(posedge clk) begin
    if (cmd.vel_start) vm <= div_q[15:0];
  end

  // Wheel speeds are registered on wheel_calc, duties with the result on out_load.
  // The factors one plus and one minus the position get two bits over its width.
  logic signed [POS_W+1:0] lf, rf;
  logic signed [40:0] lsp, rsp;
  logic        [7:0]  lduty, rduty;

  assign lf = (POS_W + 2)'(1 << FRAC_BITS) + (POS_W + 2)'($signed(held));
  assign rf = (POS_W + 2)'(1 << FRAC_BITS) - (POS_W + 2)'($signed(held));

  always_ff @(posedge clk) begin
    if (cmd.wheel_calc) begin
      lsp <= $signed({25'd0, vm}) * 41'(lf);
      rsp <= $signed({25'd0, vm}) * 41'(rf);
    end
  end

  function automatic logic [7:0] duty_of(input logic signed [40:0] sp, input logic [7:0] pm);
    logic [40:0] mag;
    logic [40:0] rest;
    logic [48:0] prod;
    begin
      mag = sp[40] ? 41'(-sp) : sp;
      rest = (41'd1 << ONE_SH) - mag;
      prod = 49'(rest) * 49'(pm);
      if (mag >= (41'd1 << ONE_SH)) duty_of = 8'd0;
      else duty_of = 8'(prod >> ONE_SH);
    end
  endfunction

  assign lduty = duty_of(lsp, cfg_pwm_max);
  assign rduty = duty_of(rsp, cfg_pwm_max);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.update_valid   <= updated;
      result.steer_position <= held;
      result.left_reverse   <= lsp[40];
      result.left_duty      <= lduty;
      result.right_reverse  <= rsp[40];
      result.right_duty     <= rduty;
    end
  end

endmodule

[rtl/core/lcs_control.sv]
module lcs_control
  import lcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  lcs_status_t status,
  output lcs_cmd_t    cmd
);

  localparam logic [2:0] S_PIXEL  = 3'd0;
  localparam logic [2:0] S_PDIV   = 3'd1;
  localparam logic [2:0] S_VSTART = 3'd2;
  localparam logic [2:0] S_VDIV   = 3'd3;
  localparam logic [2:0] S_WHEEL  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_HOLD   = 3'd6;

  logic [2:0] state, state_next;
  logic       out_busy;
  logic       waited;

  assign in_ready  = (state == S_PIXEL);
  assign out_valid = out_busy;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_PIXEL: begin
        if (in_valid) begin
          cmd.accumulate = 1'b1;
          if (status.frame_end) state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (status.pos_needed) begin
          cmd.div_start = 1'b1;
          state_next = S_PDIV;
        end else begin
          cmd.pos_load = 1'b1;
          state_next = S_VSTART;
        end
      end
      S_PDIV: begin
        if (status.div_done && waited) begin
          cmd.pos_load = 1'b1;
          state_next = S_VSTART;
        end
      end
      S_VSTART: begin
        cmd.div_start = 1'b1;
        state_next = S_VDIV;
      end
      S_VDIV: begin
        if (status.div_done && waited) begin
          cmd.vel_start = 1'b1;
          state_next = S_WHEEL;
        end
      end
      S_WHEEL: begin
        cmd.wheel_calc = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_PIXEL;
        end
      end
      default: state_next = S_PIXEL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PIXEL;
      out_busy <= 1'b0;
      waited <= 1'b0;
    end else begin
      state <= state_next;
      waited <= !cmd.div_start && (state == S_PDIV || state == S_VDIV);
      if (cmd.out_load) out_busy <= 1'b1;
      else if (out_ready) out_busy <= 1'b0;
    end
  end

endmodule

[rtl/core/line_centroid_steering.sv]
// Weighted-centroid line follower. Pixels enter one per cycle on pix_in while
// a frame is collected. On the last pixel of a frame the block stops taking
// pixels and works out the new steering position and the two wheel commands
// in the shared bit-serial divider: two 64-step divisions when the frame's
// weight passes the minimum, or only the speed division when it does not.
// After that the result is offered on res_out and the next pixel is taken; a
// result still waiting for the receiver holds the block only when the next
// frame's result is ready. A result that waits in the output register does
// not hold back the next frame's pixels. Configuration must be written through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this.
module line_centroid_steering
  import lcs_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  lcs_pixel_if.sink            pix_in,
  lcs_result_if.source         res_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [8:0]  line_width;
  logic [6:0]  line_count;
  logic [21:0] min_weight;
  logic [14:0] pos_gain;
  logic [15:0] base_velocity;
  logic [14:0] curve_decel;
  logic [7:0]  pwm_max;

  // Register file: plain write port, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= 9'd160;
      line_count    <= 7'd24;
      min_weight    <= 22'd100;
      pos_gain      <= 15'd8192;
      base_velocity <= 16'd8847;
      curve_decel   <= 15'd1024;
      pwm_max       <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:    line_width    <= cfg_data[8:0];
        REG_LINE_COUNT:    line_count    <= cfg_data[6:0];
        REG_MIN_WEIGHT:    min_weight    <= cfg_data[21:0];
        REG_POS_GAIN:      pos_gain      <= cfg_data[14:0];
        REG_BASE_VELOCITY: base_velocity <= cfg_data[15:0];
        REG_CURVE_DECEL:   curve_decel   <= cfg_data[14:0];
        REG_PWM_MAX:       pwm_max       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lcs_cmd_t    cmd;
  lcs_status_t status;
  lcs_result_t result;

  // The datapath also reports through status whether this frame's weight
  // passed the minimum, which decides if the position division runs.
  lcs_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .pixel(pix_in.pixel), .frame_start(pix_in.frame_start),
    .cfg_line_width(line_width), .cfg_line_count(line_count),
    .cfg_min_weight(min_weight), .cfg_pos_gain(pos_gain),
    .cfg_base_velocity(base_velocity), .cfg_curve_decel(curve_decel),
    .cfg_pwm_max(pwm_max), .result(result)
  );

  lcs_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(pix_in.valid), .in_ready(pix_in.ready),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .status(status), .cmd(cmd)
  );

  assign res_out.update_valid   = result.update_valid;
  assign res_out.steer_position = result.steer_position;
  assign res_out.left_reverse   = result.left_reverse;
  assign res_out.left_duty      = result.left_duty;
  assign res_out.right_reverse  = result.right_reverse;
  assign res_out.right_duty     = result.right_duty;

  // A pixel is never taken while the frame's end work is running.
  a_no_pix_in_calc: assert property (@(posedge clk) disable iff (rst)
    (cmd.accumulate && status.frame_end) |=> !pix_in.ready)
    else $error("pixel accepted during end-of-frame work");

  // The output register is loaded only when it is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!res_out.valid || res_out.ready))
    else $error("result overwritten before transfer");

endmodule
